// ===== rtl/hmi_pkg.sv =====
// Shared types, constants and delta encoding for the HMI track converter.
// Used by hmi_cell, hmi_queue and hmi_track_to_midi_events; no dependencies.
package hmi_pkg;

    localparam logic [31:0] OFFSET_POS  = 32'h0000_0057;
    localparam logic [7:0]  OFFSET_MIN  = 8'h57;
    localparam logic [7:0]  DATA_FIRST  = 8'h58;
    localparam logic [31:0] POS_MAX     = 32'hFFFF_FFFF;
    localparam logic [7:0]  CMD_SPECIAL = 8'hFE;
    localparam logic [7:0]  SUB_LEN_PRE = 8'h10;
    localparam logic [7:0]  SUB_SKIP2   = 8'h14;
    localparam logic [7:0]  SUB_SKIP6   = 8'h15;
    localparam logic [7:0]  META_STATUS = 8'hFF;
    localparam logic [7:0]  META_EOT    = 8'h2F;
    localparam logic [4:0]  MAX_FLUSH   = 5'd30;
    localparam int          OUT_W       = 104;

    typedef enum logic [3:0] {
        PH_HEADER, PH_DELTA, PH_FIRST, PH_VALUE, PH_DATA2,
        PH_DUR, PH_SKIP_PRE, PH_SKIP_LEN, PH_SKIP, PH_DONE
    } phase_t;

    // One queued note-off
    typedef struct packed {
        logic        v;
        logic [31:0] tstamp;
        logic [7:0]  cmd;
        logic [7:0]  note;
    } qent_t;

    // Queue control broadcast to every cell
    typedef struct packed {
        logic  ins;
        logic  pop;
        logic  clr;
        qent_t ent;
    } qctl_t;

    // Number of 7-bit groups needed for a delta (1..5)
    function automatic logic [2:0] vlq_groups(input logic [31:0] d);
        logic [2:0] g;
        g = 3'd1;
        if (d[31:7]  != '0) g = 3'd2;
        if (d[31:14] != '0) g = 3'd3;
        if (d[31:21] != '0) g = 3'd4;
        if (d[31:28] != '0) g = 3'd5;
        return g;
    endfunction

    // Variable-length code, right aligned, first byte most significant
    function automatic logic [39:0] vlq_code(input logic [31:0] d, input logic [2:0] g);
        logic [34:0] dx;
        logic [39:0] c;
        dx = {3'b000, d};
        c  = '0;
        for (int i = 0; i < 5; i++) begin
            if (3'(i) < g) begin
                c[8*i +: 7] = dx[7*i +: 7];
                c[8*i + 7]  = (i > 0);
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/hmi_cell.sv =====
// One cell of the time-sorted note-off row.
// Depends on hmi_pkg for the entry and control types.
module hmi_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  hmi_pkg::qctl_t ctl,
    input  hmi_pkg::qent_t left,
    input  hmi_pkg::qent_t right,
    output hmi_pkg::qent_t ent
);
    import hmi_pkg::*;

    qent_t ent_reg;
    qent_t ent_next;
    logic  later_me;
    logic  later_left;

    assign later_me   = !ent_reg.v || (ent_reg.tstamp > ctl.ent.tstamp);
    assign later_left = !left.v || (left.tstamp > ctl.ent.tstamp);

    // Shift right on insert, left on pop
    always_comb
    begin
        ent_next = ent_reg;
        if (ctl.clr)
        begin
            ent_next.v = 1'b0;
        end
        else if (ctl.pop)
        begin
            ent_next = right;
        end
        else if (ctl.ins && later_me)
        begin
            if (later_left)
                ent_next = left;
            else
                ent_next = ctl.ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ent_reg <= '0;
        else
            ent_reg <= ent_next;
    end

    assign ent = ent_reg;

endmodule

// ===== rtl/hmi_queue.sv =====
// Row of note-off cells kept sorted by time, ties in arrival order.
// Depends on hmi_pkg and hmi_cell.
module hmi_queue #(
    parameter int DEPTH = 30
) (
    input  logic           clk,
    input  logic           rst_n,
    input  hmi_pkg::qctl_t ctl,
    output hmi_pkg::qent_t head,
    output logic           full
);
    import hmi_pkg::*;

    qent_t cells [DEPTH];
    qent_t lefts [DEPTH];
    qent_t rights[DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            // Left of the first cell never counts as later than the insert
            if (i == 0)
                assign lefts[i] = '{v: 1'b1, tstamp: '0, cmd: '0, note: '0};
            else
                assign lefts[i] = cells[i-1];
            if (i == DEPTH - 1)
                assign rights[i] = '0;
            else
                assign rights[i] = cells[i+1];
            hmi_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl),
                .left  (lefts[i]),
                .right (rights[i]),
                .ent   (cells[i])
            );
        end
    endgenerate

    assign head = cells[0];
    assign full = cells[DEPTH-1].v;

endmodule

// ===== rtl/hmi_track_to_midi_events.sv =====
// HMI track to MIDI event converter, top level.
// Depends on hmi_pkg and hmi_queue.
//
// Usage:
//   Slave stream: one track byte per beat, s_tdata[7:0] = byte, s_tlast on the
//   final byte of the track. Master stream: one MIDI event per beat, tlast marks
//   the final event of the track.
//   One byte is taken at a time. A byte passes through the accept, parse, flush,
//   event and close states whether or not it emits an event. The flush state
//   stays for each due note-off drained from the sorted row and loads its beat.
//   Note-off insertion into the cell row is made from the parse state.
//   A byte's note-off beats are loaded in the flush state, its event in the event
//   state and the end marker after the last byte in the close state.
//   When the receiver stalls, the output register holds its beat and parsing
//   waits at the next event to emit; no byte is taken until all results of
//   the current byte are loaded.
//   Reset clears all parse state and empties the note-off row at once. After
//   the byte marked tlast, the block returns to the same state for the next
//   track.
module hmi_track_to_midi_events #(
    parameter int QUEUE_DEPTH = 30
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,  // [7:0] in_byte
    input  logic                      s_tlast,  // last
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [39:0] delta_code, [42:40] delta_len, [50:43] status_byte,
    // [52:51] data_count, [60:53] data_first, [68:61] data_second,
    // [100:69] body_length, [103:101] zero
    output logic [hmi_pkg::OUT_W-1:0] m_tdata,
    output logic                      m_tlast   // final_event
);
    import hmi_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_PARSE, S_FLUSH, S_EVENT, S_END} state_t;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [31:0] bpos_reg, bpos_next;
    logic [7:0]  dstart_reg, dstart_next;
    logic [7:0]  rcmd_reg, rcmd_next;
    logic [31:0] song_reg, song_next;
    logic [31:0] etime_reg, etime_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  evval_reg, evval_next;
    logic [8:0]  skip_reg, skip_next;
    logic        done_reg, done_next;
    logic [31:0] count_reg, count_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic        pflush_reg, pflush_next;
    logic        pev_reg, pev_next;
    logic [1:0]  evcnt_reg, evcnt_next;
    logic [7:0]  evd1_reg, evd1_next;
    logic [7:0]  evd2_reg, evd2_next;
    logic        evfin_reg, evfin_next;
    logic [4:0]  nflush_reg, nflush_next;

    logic              ovalid_reg;
    logic [OUT_W-1:0]  odata_reg;
    logic              olast_reg;

    logic        ld;
    logic [31:0] ld_delta;
    logic [7:0]  ld_status;
    logic [1:0]  ld_cnt;
    logic [7:0]  ld_d1;
    logic [7:0]  ld_d2;
    logic        ld_fin;
    logic [2:0]  ld_grp;
    logic [32:0] ld_sum;
    logic [31:0] ld_count;
    logic [OUT_W-1:0] ld_data;

    logic  slot_free;
    qctl_t qctl;
    qent_t qhead;
    logic  qfull;

    assign slot_free = !ovalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = ovalid_reg;
    assign m_tdata   = odata_reg;
    assign m_tlast   = olast_reg;

    hmi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (qctl),
        .head  (qhead),
        .full  (qfull)
    );

    // Parse, sequence results and update track state
    always_comb
    begin
        logic        go;
        logic        tv;
        logic [7:0]  b;
        logic [7:0]  dst;
        logic [7:0]  start;
        logic [31:0] acc_new;
        logic [8:0]  sk;
        logic        due;
        phase_t      eph;

        state_next  = state_reg;
        phase_next  = phase_reg;
        bpos_next   = bpos_reg;
        dstart_next = dstart_reg;
        rcmd_next   = rcmd_reg;
        song_next   = song_reg;
        etime_next  = etime_reg;
        acc_next    = acc_reg;
        evval_next  = evval_reg;
        skip_next   = skip_reg;
        done_next   = done_reg;
        count_next  = count_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        pflush_next = pflush_reg;
        pev_next    = pev_reg;
        evcnt_next  = evcnt_reg;
        evd1_next   = evd1_reg;
        evd2_next   = evd2_reg;
        evfin_next  = evfin_reg;
        nflush_next = nflush_reg;
        qctl        = '0;
        ld          = 1'b0;
        ld_delta    = '0;
        ld_status   = '0;
        ld_cnt      = '0;
        ld_d1       = '0;
        ld_d2       = '0;
        ld_fin      = 1'b0;
        go          = 1'b0;
        tv          = 1'b0;
        b           = byte_reg;
        dst         = (bpos_reg == OFFSET_POS) ? byte_reg : dstart_reg;
        start       = (dst > OFFSET_MIN) ? dst : DATA_FIRST;
        acc_new     = {acc_reg[24:0], byte_reg[6:0]};
        sk          = (skip_reg != '0) ? skip_reg - 9'd1 : '0;
        due         = qhead.v && (qhead.tstamp < song_reg) && (nflush_reg != MAX_FLUSH);
        eph         = (phase_reg == PH_HEADER) ? PH_DELTA : phase_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    byte_next   = s_tdata;
                    last_next   = s_tlast;
                    pflush_next = 1'b0;
                    pev_next    = 1'b0;
                    nflush_next = '0;
                    state_next  = S_PARSE;
                end
            end
            S_PARSE:
            begin
                if (!done_reg)
                begin
                    if (phase_reg == PH_HEADER)
                    begin
                        dstart_next = dst;
                        if (bpos_reg >= {24'h0, DATA_FIRST} && bpos_reg >= {24'h0, start})
                        begin
                            go         = 1'b1;
                            phase_next = PH_DELTA;
                        end
                        if (bpos_reg != POS_MAX)
                            bpos_next = bpos_reg + 32'd1;
                    end
                    else
                    begin
                        go = 1'b1;
                    end
                end
                if (go)
                begin
                    case (eph)
                        PH_DELTA, PH_DUR:
                        begin
                            if (b[7])
                            begin
                                acc_next = acc_new;
                            end
                            else
                            begin
                                if (eph == PH_DELTA)
                                begin
                                    song_next  = song_reg + acc_new;
                                    phase_next = PH_FIRST;
                                end
                                else
                                begin
                                    qctl.ins        = !qfull;
                                    qctl.ent.v      = 1'b1;
                                    qctl.ent.tstamp = song_reg + acc_new;
                                    qctl.ent.cmd    = rcmd_reg;
                                    qctl.ent.note   = evval_reg;
                                    phase_next      = PH_DELTA;
                                end
                                acc_next = '0;
                            end
                        end
                        PH_FIRST:
                        begin
                            if (b[7])
                            begin
                                rcmd_next  = b;
                                phase_next = PH_VALUE;
                            end
                            else
                            begin
                                tv = 1'b1;
                            end
                        end
                        PH_VALUE:
                        begin
                            tv = 1'b1;
                        end
                        PH_DATA2:
                        begin
                            pflush_next = 1'b1;
                            pev_next    = 1'b1;
                            evcnt_next  = 2'd2;
                            evd1_next   = evval_reg;
                            evd2_next   = b;
                            if (rcmd_reg[7:4] == 4'hF)
                            begin
                                evfin_next = 1'b1;
                                done_next  = 1'b1;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                evfin_next = 1'b0;
                                acc_next   = '0;
                                phase_next = (rcmd_reg[7:4] == 4'h9) ? PH_DUR : PH_DELTA;
                            end
                        end
                        PH_SKIP_PRE:
                        begin
                            skip_next = skip_reg - 9'd1;
                            if (skip_reg == 9'd1)
                                phase_next = PH_SKIP_LEN;
                        end
                        PH_SKIP_LEN:
                        begin
                            skip_next  = {1'b0, b} + 9'd4;
                            phase_next = PH_SKIP;
                        end
                        PH_SKIP:
                        begin
                            skip_next = sk;
                            if (sk == '0)
                                phase_next = PH_DELTA;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                // Take a value byte under the running command
                if (tv)
                begin
                    evval_next = b;
                    if (rcmd_reg == CMD_SPECIAL)
                    begin
                        pflush_next = 1'b1;
                        case (b)
                            SUB_LEN_PRE:
                            begin
                                skip_next  = 9'd2;
                                phase_next = PH_SKIP_PRE;
                            end
                            SUB_SKIP2:
                            begin
                                skip_next  = 9'd2;
                                phase_next = PH_SKIP;
                            end
                            SUB_SKIP6:
                            begin
                                skip_next  = 9'd6;
                                phase_next = PH_SKIP;
                            end
                            default:
                            begin
                                phase_next = PH_DELTA;
                            end
                        endcase
                    end
                    else
                    begin
                        case (rcmd_reg[7:4]) inside
                            4'hC, 4'hD:
                            begin
                                pflush_next = 1'b1;
                                pev_next    = 1'b1;
                                evcnt_next  = 2'd1;
                                evd1_next   = b;
                                evd2_next   = '0;
                                evfin_next  = 1'b0;
                                phase_next  = PH_DELTA;
                            end
                            4'h8, 4'h9, 4'hA, 4'hB, 4'hE, 4'hF:
                            begin
                                phase_next = PH_DATA2;
                            end
                            default:
                            begin
                                pflush_next = 1'b1;
                                pev_next    = 1'b1;
                                evcnt_next  = 2'd0;
                                evd1_next   = '0;
                                evd2_next   = '0;
                                evfin_next  = 1'b0;
                                phase_next  = PH_DELTA;
                            end
                        endcase
                    end
                end
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                // Drain due note-offs one per beat
                if (pflush_reg && due)
                begin
                    if (slot_free)
                    begin
                        ld          = 1'b1;
                        ld_delta    = qhead.tstamp - etime_reg;
                        ld_status   = qhead.cmd;
                        ld_cnt      = 2'd2;
                        ld_d1       = qhead.note;
                        qctl.pop    = 1'b1;
                        etime_next  = qhead.tstamp;
                        nflush_next = nflush_reg + 5'd1;
                    end
                end
                else
                begin
                    state_next = S_EVENT;
                end
            end
            S_EVENT:
            begin
                if (!pev_reg)
                begin
                    state_next = S_END;
                end
                else if (slot_free)
                begin
                    ld         = 1'b1;
                    ld_delta   = song_reg - etime_reg;
                    ld_status  = rcmd_reg;
                    ld_cnt     = evcnt_reg;
                    ld_d1      = evd1_reg;
                    ld_d2      = evd2_reg;
                    ld_fin     = evfin_reg;
                    etime_next = song_reg;
                    state_next = S_END;
                end
            end
            S_END:
            begin
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (done_reg || slot_free)
                begin
                    if (!done_reg)
                    begin
                        ld        = 1'b1;
                        ld_status = META_STATUS;
                        ld_cnt    = 2'd2;
                        ld_d1     = META_EOT;
                        ld_fin    = 1'b1;
                    end
                    qctl.clr   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Encode the loaded beat and advance the body length
        ld_grp   = vlq_groups(ld_delta);
        ld_sum   = {1'b0, count_reg} + {30'h0, ld_grp} + {31'h0, 2'd1} + {31'h0, ld_cnt};
        ld_count = ld_sum[32] ? POS_MAX : ld_sum[31:0];
        ld_data  = {3'b000, ld_count, ld_d2, ld_d1, ld_cnt, ld_status, ld_grp,
                    vlq_code(ld_delta, ld_grp)};
        if (ld)
            count_next = ld_count;

        // Return to the reset state after the last byte
        if (qctl.clr)
        begin
            phase_next  = PH_HEADER;
            bpos_next   = '0;
            dstart_next = '0;
            rcmd_next   = '0;
            song_next   = '0;
            etime_next  = '0;
            acc_next    = '0;
            evval_next  = '0;
            skip_next   = '0;
            done_next   = 1'b0;
            count_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= PH_HEADER;
            bpos_reg   <= '0;
            dstart_reg <= '0;
            rcmd_reg   <= '0;
            song_reg   <= '0;
            etime_reg  <= '0;
            acc_reg    <= '0;
            evval_reg  <= '0;
            skip_reg   <= '0;
            done_reg   <= 1'b0;
            count_reg  <= '0;
            last_reg   <= 1'b0;
            pflush_reg <= 1'b0;
            pev_reg    <= 1'b0;
            nflush_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            bpos_reg   <= bpos_next;
            dstart_reg <= dstart_next;
            rcmd_reg   <= rcmd_next;
            song_reg   <= song_next;
            etime_reg  <= etime_next;
            acc_reg    <= acc_next;
            evval_reg  <= evval_next;
            skip_reg   <= skip_next;
            done_reg   <= done_next;
            count_reg  <= count_next;
            last_reg   <= last_next;
            pflush_reg <= pflush_next;
            pev_reg    <= pev_next;
            nflush_reg <= nflush_next;
            // Hold the beat until taken
            if (ld)
                ovalid_reg <= 1'b1;
            else if (m_tready)
                ovalid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        evcnt_reg <= evcnt_next;
        evd1_reg  <= evd1_next;
        evd2_reg  <= evd2_next;
        evfin_reg <= evfin_next;
        if (ld)
        begin
            odata_reg <= ld_data;
            olast_reg <= ld_fin;
        end
    end

    a_accept_parses: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == S_PARSE)
        else $error("accepted byte not parsed next");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        qctl.pop |-> qhead.v)
        else $error("pop from empty note-off row");

    a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        qctl.ins |-> !qfull)
        else $error("insert into full note-off row");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ld |-> slot_free)
        else $error("output beat overwritten");

    a_flush_limit: assert property (@(posedge clk) disable iff (!rst_n)
        qctl.pop |-> nflush_reg != MAX_FLUSH)
        else $error("flush limit exceeded");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for hmi_track_to_midi_events: streams HMI track bytes
// and checks every MIDI event beat against a built-in converter model.
// Depends on hmi_pkg and the RTL of the converter.
`timescale 1ns / 100ps

module tb;
    import hmi_pkg::*;

    localparam int NOTE_SLOTS = 30;
    localparam int FLUSH_CAP  = 30;
    localparam int STEP_CAP   = 32;

    typedef struct {
        logic [39:0] delta_code;
        logic [2:0]  delta_len;
        logic [7:0]  status_byte;
        logic [1:0]  data_count;
        logic [7:0]  data_first;
        logic [7:0]  data_second;
        logic [31:0] body_length;
        logic        final_event;
    } midi_ev_t;

    typedef struct {
        logic [7:0] in_byte;
        logic       last;
        logic       typed;
        midi_ev_t   ev;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tlast;

    // Converter model state
    logic [31:0] cv_pos;
    logic [7:0]  cv_start;
    phase_t      cv_phase;
    logic [7:0]  cv_cmd;
    logic [31:0] cv_song;
    logic [31:0] cv_emitted;
    logic [31:0] cv_vacc;
    logic [7:0]  cv_value;
    logic [15:0] cv_skip;
    logic        cv_done;
    logic [31:0] cv_body;
    logic [31:0] off_time [NOTE_SLOTS];
    logic [7:0]  off_cmd  [NOTE_SLOTS];
    logic [7:0]  off_note [NOTE_SLOTS];
    int          off_count;
    int          step_events;

    midi_ev_t    pending_events[$];
    logic [7:0]  track_bytes[$];
    int          src_idle = 9;
    int          snk_idle = 61;
    int          errors = 0;
    int          bytes_sent = 0;
    int          events_seen = 0;
    int          tracks_sent = 0;

    hmi_track_to_midi_events DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Return converter model to its idle state
    task automatic clear_converter();
        cv_pos     = '0;
        cv_start   = '0;
        cv_phase   = PH_HEADER;
        cv_cmd     = '0;
        cv_song    = '0;
        cv_emitted = '0;
        cv_vacc    = '0;
        cv_value   = '0;
        cv_skip    = '0;
        cv_done    = 1'b0;
        cv_body    = '0;
        off_count  = 0;
        for (int i = 0; i < NOTE_SLOTS; i++)
        begin
            off_time[i] = '1;
            off_cmd[i]  = '1;
            off_note[i] = '1;
        end
    endtask

    // Encode delta and queue one expected event
    task automatic queue_event(input logic [31:0] d, input logic [7:0] st,
                               input logic [1:0] c, input logic [7:0] a,
                               input logic [7:0] b, input logic f);
        int          g;
        logic [39:0] code;
        logic [7:0]  grp;
        logic [31:0] sum;
        midi_ev_t    e;
        if (step_events >= STEP_CAP)
            return;
        g = 1;
        while (g < 5 && (d >> (7 * g)) != 0)
            g++;
        code = '0;
        for (int i = g - 1; i >= 0; i--)
        begin
            grp = 8'((d >> (7 * i)) & 32'h7F);
            if (i > 0)
                grp[7] = 1'b1;
            code = {code[31:0], grp};
        end
        sum = 32'(g) + 32'd1 + 32'(c);
        if (cv_body > 32'hFFFF_FFFF - sum)
            cv_body = '1;
        else
            cv_body = cv_body + sum;
        e.delta_code  = code;
        e.delta_len   = 3'(g);
        e.status_byte = st;
        e.data_count  = c;
        e.data_first  = (c >= 1) ? a : 8'h00;
        e.data_second = (c >= 2) ? b : 8'h00;
        e.body_length = cv_body;
        e.final_event = f;
        pending_events = {pending_events, e};
        step_events++;
    endtask

    // Emit note-offs that are due before the current song time
    task automatic flush_note_offs();
        int n;
        n = 0;
        while (n < off_count && n < FLUSH_CAP && off_time[n] < cv_song)
        begin
            queue_event(off_time[n] - cv_emitted, off_cmd[n], 2'd2, off_note[n], 8'h00, 1'b0);
            cv_emitted = off_time[n];
            n++;
        end
        for (int k = n; k < off_count; k++)
        begin
            off_time[k - n] = off_time[k];
            off_cmd[k - n]  = off_cmd[k];
            off_note[k - n] = off_note[k];
        end
        off_count -= n;
    endtask

    // Sorted insert, ties after equal times, drop when full
    task automatic store_note_off(input logic [31:0] t, input logic [7:0] c,
                                  input logic [7:0] nt);
        int p;
        if (off_count >= NOTE_SLOTS)
            return;
        p = off_count;
        while (p > 0 && off_time[p - 1] > t)
        begin
            off_time[p] = off_time[p - 1];
            off_cmd[p]  = off_cmd[p - 1];
            off_note[p] = off_note[p - 1];
            p--;
        end
        off_time[p] = t;
        off_cmd[p]  = c;
        off_note[p] = nt;
        off_count++;
    endtask

    task automatic channel_event(input logic [1:0] c, input logic [7:0] a,
                                 input logic [7:0] b, input logic f);
        queue_event(cv_song - cv_emitted, cv_cmd, c, a, b, f);
        cv_emitted = cv_song;
    endtask

    task automatic take_value(input logic [7:0] v);
        cv_value = v;
        if (cv_cmd == CMD_SPECIAL)
        begin
            flush_note_offs();
            if (v == SUB_LEN_PRE)
            begin
                cv_skip  = 16'd2;
                cv_phase = PH_SKIP_PRE;
            end
            else if (v == SUB_SKIP2)
            begin
                cv_skip  = 16'd2;
                cv_phase = PH_SKIP;
            end
            else if (v == SUB_SKIP6)
            begin
                cv_skip  = 16'd6;
                cv_phase = PH_SKIP;
            end
            else
                cv_phase = PH_DELTA;
            return;
        end
        case (cv_cmd[7:4])
            4'hC, 4'hD:
            begin
                flush_note_offs();
                channel_event(2'd1, v, 8'h00, 1'b0);
                cv_phase = PH_DELTA;
            end
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE, 4'hF:
                cv_phase = PH_DATA2;
            default:
            begin
                flush_note_offs();
                channel_event(2'd0, 8'h00, 8'h00, 1'b0);
                cv_phase = PH_DELTA;
            end
        endcase
    endtask

    task automatic parse_event_byte(input logic [7:0] b);
        case (cv_phase)
            PH_DELTA, PH_DUR:
            begin
                cv_vacc = {cv_vacc[24:0], b[6:0]};
                if (!b[7])
                begin
                    if (cv_phase == PH_DELTA)
                    begin
                        cv_song  = cv_song + cv_vacc;
                        cv_phase = PH_FIRST;
                    end
                    else
                    begin
                        store_note_off(cv_song + cv_vacc, cv_cmd, cv_value);
                        cv_phase = PH_DELTA;
                    end
                    cv_vacc = '0;
                end
            end
            PH_FIRST:
                if (b >= 8'h80)
                begin
                    cv_cmd   = b;
                    cv_phase = PH_VALUE;
                end
                else
                    take_value(b);
            PH_VALUE:
                take_value(b);
            PH_DATA2:
            begin
                flush_note_offs();
                if (cv_cmd[7:4] == 4'hF)
                begin
                    channel_event(2'd2, cv_value, b, 1'b1);
                    cv_done  = 1'b1;
                    cv_phase = PH_DONE;
                end
                else
                begin
                    channel_event(2'd2, cv_value, b, 1'b0);
                    cv_vacc  = '0;
                    cv_phase = (cv_cmd[7:4] == 4'h9) ? PH_DUR : PH_DELTA;
                end
            end
            PH_SKIP_PRE:
            begin
                cv_skip--;
                if (cv_skip == 0)
                    cv_phase = PH_SKIP_LEN;
            end
            PH_SKIP_LEN:
            begin
                cv_skip  = 16'(b) + 16'd4;
                cv_phase = PH_SKIP;
            end
            PH_SKIP:
            begin
                if (cv_skip > 0)
                    cv_skip--;
                if (cv_skip == 0)
                    cv_phase = PH_DELTA;
            end
            default: ;
        endcase
    endtask

    // Advance the converter model by one accepted byte
    task automatic convert_byte(input logic [7:0] b, input logic l);
        logic [31:0] first_pos;
        step_events = 0;
        if (!cv_done)
        begin
            if (cv_phase == PH_HEADER)
            begin
                if (cv_pos == OFFSET_POS)
                    cv_start = b;
                first_pos = (cv_start > OFFSET_MIN) ? 32'(cv_start) : 32'(DATA_FIRST);
                if (cv_pos >= 32'(DATA_FIRST) && cv_pos >= first_pos)
                begin
                    cv_phase = PH_DELTA;
                    parse_event_byte(b);
                end
                if (cv_pos != POS_MAX)
                    cv_pos++;
            end
            else
                parse_event_byte(b);
        end
        if (l)
        begin
            if (!cv_done)
                queue_event(32'd0, META_STATUS, 2'd2, META_EOT, 8'h00, 1'b1);
            clear_converter();
        end
    endtask

    // Offer one byte, hold it until accepted
    task automatic send_byte(input logic [7:0] b, input logic l);
        if ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
    endtask

    // Append one byte to the track under construction
    task automatic add_byte(input logic [7:0] v);
        track_bytes = {track_bytes, v};
    endtask

    task automatic add_vlq(input logic [31:0] v);
        int g;
        g = 1;
        while (g < 5 && (v >> (7 * g)) != 0)
            g++;
        // occasionally prepend an extra group so the value can wrap
        if ($urandom_range(19) == 0)
            add_byte(8'h80 | 8'($urandom_range(127)));
        for (int i = g - 1; i >= 0; i--)
            add_byte(8'((v >> (7 * i)) & 32'h7F) | ((i > 0) ? 8'h80 : 8'h00));
    endtask

    task automatic add_event(inout logic [7:0] run_cmd, input logic [31:0] delta);
        logic [7:0] st;
        logic [7:0] sub;
        int         len;
        int         r;
        add_vlq(delta);
        r = $urandom_range(99);
        if (r < 25 && run_cmd != 8'h00)
        begin
            st = run_cmd;
            add_byte(8'($urandom_range(127)));
        end
        else if (r < 28 && run_cmd == 8'h00)
        begin
            // value with no command seen yet
            add_byte(8'($urandom_range(127)));
            return;
        end
        else
        begin
            case ($urandom_range(7))
                0, 1, 2: st = 8'h90;
                3:       st = 8'h80 | (8'($urandom_range(3)) << 4);
                4:       st = 8'hE0;
                5:       st = 8'hC0 | (8'($urandom_range(1)) << 4);
                default: st = CMD_SPECIAL;
            endcase
            if (st != CMD_SPECIAL)
                st = st | 8'($urandom_range(15));
            run_cmd = st;
            add_byte(st);
            add_byte(8'($urandom_range(255)));
        end
        if (st == CMD_SPECIAL)
        begin
            // replace the value with a real subtype most of the time
            sub = track_bytes.pop_back();
            case ($urandom_range(3))
                0:       sub = SUB_LEN_PRE;
                1:       sub = SUB_SKIP2;
                2:       sub = SUB_SKIP6;
                default: ;
            endcase
            if (r < 25)
                sub = sub & 8'h7F;
            add_byte(sub);
            if (sub == SUB_LEN_PRE)
            begin
                len = $urandom_range(0, 5);
                add_byte(8'($urandom_range(255)));
                add_byte(8'($urandom_range(255)));
                add_byte(8'(len));
                repeat (len + 4) add_byte(8'($urandom_range(255)));
            end
            else if (sub == SUB_SKIP2)
                repeat (2) add_byte(8'($urandom_range(255)));
            else if (sub == SUB_SKIP6)
                repeat (6) add_byte(8'($urandom_range(255)));
        end
        else if (st[7:4] != 4'hC && st[7:4] != 4'hD)
        begin
            add_byte(8'($urandom_range(255)));
            if (st[7:4] == 4'h9)
                add_vlq(($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(0, 40)));
        end
    endtask

    // Build one track: header, offset, padding, events, ending
    task automatic build_track(input int nev, input bit crowd);
        logic [7:0] off;
        logic [7:0] run_cmd;
        int         cut;
        track_bytes.delete();
        run_cmd = 8'h00;
        repeat (int'(OFFSET_POS)) add_byte(8'($urandom_range(255)));
        case ($urandom_range(9))
            0:       off = 8'($urandom_range(0, 16'h57));
            1:       off = 8'h58 + 8'($urandom_range(7, 24));
            default: off = 8'h58 + 8'($urandom_range(0, 6));
        endcase
        add_byte(off);
        while (track_bytes.size() < int'(off))
            add_byte(8'($urandom_range(255)));
        if (crowd)
        begin
            // more note-ons than slots under running status, then a long gap
            for (int i = 0; i < NOTE_SLOTS + 1; i++)
            begin
                add_vlq(32'd0);
                if (i == 0)
                    add_byte(8'h90 | 8'($urandom_range(15)));
                add_byte(8'($urandom_range(127)));
                add_byte(8'($urandom_range(255)));
                add_vlq(32'(100 + $urandom_range(0, 3)));
            end
            add_vlq(32'd1000);
            add_byte(8'hC0);
            add_byte(8'h05);
            run_cmd = 8'hC0;
        end
        for (int i = 0; i < nev; i++)
            add_event(run_cmd, ($urandom_range(7) == 0) ? $urandom()
                                                      : 32'($urandom_range(0, 20)));
        case ($urandom_range(5))
            0:
            begin
                // F-type event ends the track, trailing bytes ignored
                add_vlq(32'($urandom_range(0, 5)));
                add_byte(($urandom_range(1) == 0) ? META_STATUS
                         : 8'hF0 | 8'($urandom_range(13)));
                add_byte(8'($urandom_range(255)));
                add_byte(8'($urandom_range(255)));
                repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(255)));
            end
            1:
            begin
                // end inside the last event
                cut = int'(track_bytes.size()) - int'($urandom_range(1, 3));
                while (track_bytes.size() > cut)
                    void'(track_bytes.pop_back());
            end
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0)
            @(posedge clk);
    endtask

    // Compare each accepted event beat with the oldest expectation
    always @(posedge clk)
    begin
        midi_ev_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            events_seen++;
            if (pending_events.size() == 0)
            begin
                $error("unexpected event beat %h", m_tdata);
                errors++;
            end
            else
            begin
                e = pending_events.pop_front();
                if (m_tdata[39:0] !== e.delta_code)
                begin
                    $error("delta_code exp %h got %h", e.delta_code, m_tdata[39:0]);
                    errors++;
                end
                if (m_tdata[42:40] !== e.delta_len)
                begin
                    $error("delta_len exp %0d got %0d", e.delta_len, m_tdata[42:40]);
                    errors++;
                end
                if (m_tdata[50:43] !== e.status_byte)
                begin
                    $error("status_byte exp %h got %h", e.status_byte, m_tdata[50:43]);
                    errors++;
                end
                if (m_tdata[52:51] !== e.data_count)
                begin
                    $error("data_count exp %0d got %0d", e.data_count, m_tdata[52:51]);
                    errors++;
                end
                if (m_tdata[60:53] !== e.data_first)
                begin
                    $error("data_first exp %h got %h", e.data_first, m_tdata[60:53]);
                    errors++;
                end
                if (m_tdata[68:61] !== e.data_second)
                begin
                    $error("data_second exp %h got %h", e.data_second, m_tdata[68:61]);
                    errors++;
                end
                if (m_tdata[100:69] !== e.body_length)
                begin
                    $error("body_length exp %0d got %0d", e.body_length, m_tdata[100:69]);
                    errors++;
                end
                if (m_tlast !== e.final_event)
                begin
                    $error("final_event exp %0d got %0d", e.final_event, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls at random
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= snk_idle);

    // Hard limit on run length
    initial
    begin
        #30_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        stim_row_t rows[$];
        stim_row_t row;
        midi_ev_t  eot;
        int        prior_count;
        int        guard;
        int        third;
        logic [7:0] extremes [4];

        clear_converter();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: short tracks cut at once give the bare end marker
        eot.delta_code  = '0;
        eot.delta_len   = 3'd1;
        eot.status_byte = META_STATUS;
        eot.data_count  = 2'd2;
        eot.data_first  = META_EOT;
        eot.data_second = 8'h00;
        eot.body_length = 32'd4;
        eot.final_event = 1'b1;
        extremes = '{8'h00, 8'hFF, 8'h7F, 8'h80};
        foreach (extremes[i])
        begin
            row = '{extremes[i], 1'b1, 1'b1, eot};
            rows = {rows, row};
        end
        foreach (extremes[i])
        begin
            row = '{extremes[i], 1'b0, 1'b0, eot};
            rows = {rows, row};
        end
        row = '{8'h57, 1'b1, 1'b1, eot};
        rows = {rows, row};
        foreach (rows[i])
        begin
            send_byte(rows[i].in_byte, rows[i].last);
            prior_count = pending_events.size();
            convert_byte(rows[i].in_byte, rows[i].last);
            if (rows[i].typed)
            begin
                while (pending_events.size() > prior_count)
                    void'(pending_events.pop_back());
                pending_events = {pending_events, rows[i].ev};
            end
        end

        // One random track crossing the three idling profiles
        build_track($urandom_range(5, 8), 1'b1);
        third = track_bytes.size() / 3;
        foreach (track_bytes[i])
        begin
            if (i == third)
            begin
                src_idle = 61;
                snk_idle = 9;
            end
            else if (i == 2 * third)
            begin
                src_idle = 0;
                snk_idle = 0;
            end
            // hold the sender until every expected beat has come
            if (i == third + third / 2)
            begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            send_byte(track_bytes[i], i == track_bytes.size() - 1);
            convert_byte(track_bytes[i], i == track_bytes.size() - 1);
        end
        tracks_sent++;
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        guard = 0;
        while (pending_events.size() != 0 && guard < 200_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (100) @(posedge clk);
        if (pending_events.size() != 0)
        begin
            $error("%0d expected events never arrived", pending_events.size());
            errors++;
        end

        $display("Sent %0d bytes in %0d random tracks plus directed cuts, checked %0d events.",
                 bytes_sent, tracks_sent, events_seen);
        $display("Covered running status, note-off store overflow, skips and early ends.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
